// ----- sv/bdq_pkg.sv -----
// ----------------------------------------------------------------------------
// bdq_pkg: shared types and constants of the bounded deque
// Operation and status codes, record layout and the cell control group.
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int unsigned CNT_W  = 7;   // count and capacity width
  localparam int unsigned IDX_W  = 6;   // read index width
  localparam int unsigned CNT_MAX = 127; // largest count the count field holds

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    OP_ADD_FIRST  = 3'd0,
    OP_ADD_LAST   = 3'd1,
    OP_REM_FIRST  = 3'd2,
    OP_REM_LAST   = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_READ_AT    = 3'd5,
    OP_READ_FIRST = 3'd6,
    OP_READ_LAST  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SCAN = 1'b1
  } fsm_e;

  // Last field in the lowest bits
  typedef struct packed {
    logic [7:0] mover_piece;
    logic [7:0] prior_piece;
    logic [2:0] from_col;
    logic [2:0] from_row;
    logic [2:0] cur_col;
    logic [2:0] cur_row;
  } rec_t;

  typedef struct packed {
    logic push_front; // every cell takes its left neighbour
    logic pop_front;  // every cell takes its right neighbour
    logic push_back;  // the cell at the count position takes the new record
    logic rd_load;    // read line copies the records
    logic rd_shift;   // read line moves one place towards the front
  } cell_ctl_t;

  typedef struct packed {
    logic       is_empty;
    logic       is_full;
    logic [CNT_W-1:0] count;
    rec_t       rec;
    status_e    status;
  } res_t;

endpackage

// ----- sv/bdq_cell.sv -----
// ----------------------------------------------------------------------------
// bdq_cell: one slot of the deque chain
// Holds a record and a read-line stage, fed by neighbours, new or own record.
// ----------------------------------------------------------------------------
module bdq_cell (
  input  logic              clk_i,
  input  bdq_pkg::cell_ctl_t ctl_i,
  input  logic              wr_here_i,
  input  bdq_pkg::rec_t     new_rec_i,
  input  bdq_pkg::rec_t     left_rec_i,
  input  bdq_pkg::rec_t     right_rec_i,
  input  bdq_pkg::rec_t     right_rd_i,
  output bdq_pkg::rec_t     rec_o,
  output bdq_pkg::rec_t     rd_o
);
  import bdq_pkg::*;

  rec_t rec_q, rec_d;
  rec_t rd_q, rd_d;

  always_comb begin
    rec_d = rec_q;
    if (ctl_i.push_front) begin
      rec_d = left_rec_i;
    end else if (ctl_i.pop_front) begin
      rec_d = right_rec_i;
    end else if (ctl_i.push_back && wr_here_i) begin
      rec_d = new_rec_i;
    end
  end

  always_comb begin
    rd_d = rd_q;
    if (ctl_i.rd_load) begin
      rd_d = rec_q;
    end else if (ctl_i.rd_shift) begin
      rd_d = right_rd_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
    rd_q  <= rd_d;
  end

  assign rec_o = rec_q;
  assign rd_o  = rd_q;

endmodule

// ----- sv/bdq_ctrl.sv -----
// ----------------------------------------------------------------------------
// bdq_ctrl: deque sequencer
// Count, capacity, op decode, read-line walk and the result register.
// ----------------------------------------------------------------------------
module bdq_ctrl #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bdq_pkg::CNT_W-1:0]  cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bdq_pkg::op_e               op_i,
  input  logic [bdq_pkg::IDX_W-1:0]  index_i,
  input  bdq_pkg::rec_t              rd_head_i,
  output bdq_pkg::cell_ctl_t         ctl_o,
  output logic [bdq_pkg::CNT_W-1:0]  count_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bdq_pkg::res_t              res_o
);
  import bdq_pkg::*;

  localparam int unsigned CAP_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

  fsm_e             state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CNT_W-1:0] cap_q;
  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic             out_v_q, out_v_d;
  res_t             res_q, res_d;

  logic             accept, out_free, is_empty, is_full;
  logic             rd_start, res_ld;
  logic [CNT_W-1:0] rd_steps;
  status_e          op_status;
  cell_ctl_t        ctl;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (cap_q > CNT_W'(CAP_MAX)) begin
      cap_eff = CNT_W'(CAP_MAX);
    end else begin
      cap_eff = cap_q;
    end
  end

  assign out_free = !out_v_q || out_ready_i;
  assign is_empty = (cnt_q == '0);
  assign is_full  = (cnt_q >= cap_eff);
  assign accept   = in_valid_i && in_ready_o;

  // op decode, effective only on a transfer
  always_comb begin
    op_status = ST_OK;
    rd_start  = 1'b0;
    rd_steps  = '0;
    cnt_d     = cnt_q;
    ctl       = '0;
    if (accept) begin
      unique case (op_i)
        OP_ADD_FIRST: begin
          if (is_full) begin
            op_status = ST_FULL;
          end else begin
            ctl.push_front = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        OP_ADD_LAST: begin
          if (is_full) begin
            op_status = ST_FULL;
          end else begin
            ctl.push_back = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
        OP_REM_FIRST: begin
          if (is_empty) begin
            op_status = ST_EMPTY;
          end else begin
            ctl.pop_front = 1'b1;
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        OP_REM_LAST: begin
          if (is_empty) begin
            op_status = ST_EMPTY;
          end else begin
            cnt_d = cnt_q - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          cnt_d = '0;
        end
        OP_READ_AT: begin
          if ({1'b0, index_i} >= cnt_q) begin
            op_status = ST_RANGE;
          end else begin
            rd_start = 1'b1;
            rd_steps = {1'b0, index_i};
          end
        end
        OP_READ_FIRST: begin
          if (is_empty) begin
            op_status = ST_EMPTY;
          end else begin
            rd_start = 1'b1;
          end
        end
        OP_READ_LAST: begin
          if (is_empty) begin
            op_status = ST_EMPTY;
          end else begin
            rd_start = 1'b1;
            rd_steps = cnt_q - CNT_W'(1);
          end
        end
        default: op_status = ST_OK;
      endcase
    end
    ctl.rd_load  = rd_start;
    ctl.rd_shift = (state_q == FSM_SCAN) && (steps_q != '0);
  end

  // next state
  always_comb begin
    state_d = state_q;
    steps_d = steps_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (rd_start) begin
          state_d = FSM_SCAN;
          steps_d = rd_steps;
        end
      end
      FSM_SCAN: begin
        if (steps_q != '0) begin
          steps_d = steps_q - CNT_W'(1);
        end else if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // outputs and result register load
  always_comb begin
    in_ready_o = 1'b0;
    res_ld     = 1'b0;
    res_d      = res_q;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = out_free;
        if (accept && !rd_start) begin
          res_ld         = 1'b1;
          res_d.status   = op_status;
          res_d.rec      = '0;
          res_d.count    = cnt_d;
          res_d.is_full  = (cnt_d >= cap_eff);
          res_d.is_empty = (cnt_d == '0);
        end
      end
      FSM_SCAN: begin
        if ((steps_q == '0) && out_free) begin
          res_ld         = 1'b1;
          res_d.status   = ST_OK;
          res_d.rec      = rd_head_i;
          res_d.count    = cnt_q;
          res_d.is_full  = is_full;
          res_d.is_empty = is_empty;
        end
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  always_comb begin
    out_v_d = out_v_q;
    if (res_ld) begin
      out_v_d = 1'b1;
    end else if (out_ready_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      steps_q <= '0;
      cnt_q   <= '0;
      cap_q   <= CAP_RESET;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ld) begin
      res_q <= res_d;
    end
  end

  assign ctl_o       = ctl;
  assign count_o     = cnt_q;
  assign out_valid_o = out_v_q;
  assign res_o       = res_q;

endmodule

// ----- sv/bounded_deque_with_indexed_read.sv -----
// ----------------------------------------------------------------------------
// bounded_deque_with_indexed_read: bounded deque of move records
// A chain of record cells with a shift-to-front read line and a small
// sequencer; add/remove at either end, clear, and reads by position.
// ----------------------------------------------------------------------------
//  channel   dir  handshake             payload
//  s_axis    in   tvalid/tready         op, index, record to add (40 bits)
//  m_axis    out  tvalid/tready         status, record read, count, flags
//  cfg       in   cfg_we_i (no stall)   capacity (7 bits)
//
//  Adds, removes, clear and failed reads: result registered in the cycle after
//  the transfer; up to one such op per cycle while results are drained.
//  Successful reads load the read line and shift it towards the front until
//  the wanted record is at slot 0; no new op is taken during the walk.
//  A new op is taken while the result register is empty or being drained.
//  Reset clears count, capacity (to 64) and control; records need no reset.
// ----------------------------------------------------------------------------
module bounded_deque_with_indexed_read #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // capacity register
  input  logic                      cfg_we_i,
  input  logic [bdq_pkg::CNT_W-1:0] cfg_wdata_i,
  // op stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // [2:0] mode, [8:3] index, [11:9] cur_row, [14:12] cur_col,
  // [17:15] from_row, [20:18] from_col, [28:21] prior_piece,
  // [36:29] mover_piece, [39:37] zero
  input  logic [39:0]               s_axis_tdata,
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // [1:0] status, [4:2] rd_cur_row, [7:5] rd_cur_col, [10:8] rd_from_row,
  // [13:11] rd_from_col, [21:14] rd_prior_piece, [29:22] rd_mover_piece,
  // [36:30] count, [37] is_full, [38] is_empty, [39] zero
  output logic [39:0]               m_axis_tdata
);
  import bdq_pkg::*;

  localparam int unsigned CAP_MAX = (DEPTH < CNT_MAX) ? DEPTH : CNT_MAX;

  op_e              in_op;
  logic [IDX_W-1:0] in_index;
  rec_t             in_rec;
  cell_ctl_t        ctl;
  logic [CNT_W-1:0] count;
  res_t             res;

  rec_t rec   [DEPTH];
  rec_t rd    [DEPTH];
  logic wr_at [DEPTH];

  assign in_op    = op_e'(s_axis_tdata[2:0]);
  assign in_index = s_axis_tdata[8:3];
  assign in_rec   = rec_t'(s_axis_tdata[36:9]);

  bdq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (in_op),
    .index_i     (in_index),
    .rd_head_i   (rd[0]),
    .ctl_o       (ctl),
    .count_o     (count),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (res)
  );

  // Cell chain: slot 0 is the front. Records move right on an add at the
  // front and left on a remove at the front; the read line only moves left.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t left_rec, right_rec, right_rd;

    if (i == 0) begin : g_head
      assign left_rec = in_rec;
    end else begin : g_mid_l
      assign left_rec = rec[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_rec = '0;
      assign right_rd  = '0;
    end else begin : g_mid_r
      assign right_rec = rec[i+1];
      assign right_rd  = rd[i+1];
    end

    // slots at or past the largest reachable count are never written at the back
    if (i < CAP_MAX) begin : g_wr
      assign wr_at[i] = (count == CNT_W'(i));
    end else begin : g_nowr
      assign wr_at[i] = 1'b0;
    end

    bdq_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .wr_here_i   (wr_at[i]),
      .new_rec_i   (in_rec),
      .left_rec_i  (left_rec),
      .right_rec_i (right_rec),
      .right_rd_i  (right_rd),
      .rec_o       (rec[i]),
      .rd_o        (rd[i])
    );
  end

  assign m_axis_tdata = {1'b0, res.is_empty, res.is_full, res.count, res.rec, res.status};

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(CAP_MAX))
    else $error("count above largest capacity");

  a_quick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_op != OP_READ_AT && in_op != OP_READ_FIRST && in_op != OP_READ_LAST)
    |=> m_axis_tvalid)
    else $error("non-read op gave no result in the next cycle");

  a_empty_flag : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.is_empty == (res.count == '0)))
    else $error("empty flag disagrees with count");

  a_shift_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl.push_front, ctl.pop_front, ctl.push_back, ctl.rd_load, ctl.rd_shift}))
    else $error("conflicting cell commands");

endmodule
